@@ sv/tfp_pkg.sv @@
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types and constants for the tensor frame parser: result kinds,
// error codes, header bytes and the result record passed to the output queue.
// ----------------------------------------------------------------------------
package tfp_pkg;

    localparam int unsigned DataByteWidth  = 8;
    localparam int unsigned KindWidth      = 3;
    localparam int unsigned ValueWidth     = 64;
    localparam int unsigned ErrorWidth     = 4;
    localparam int unsigned ResultDataBits = 72;   // kind, value, error_code, pad
    localparam int unsigned QueueDepth     = 4;

    // result kinds
    localparam logic [KindWidth-1:0] KIND_DIMS  = 3'd0;
    localparam logic [KindWidth-1:0] KIND_SHAPE = 3'd1;
    localparam logic [KindWidth-1:0] KIND_COUNT = 3'd2;
    localparam logic [KindWidth-1:0] KIND_ELEM  = 3'd3;
    localparam logic [KindWidth-1:0] KIND_DONE  = 3'd4;
    localparam logic [KindWidth-1:0] KIND_ERROR = 3'd5;

    // error codes
    localparam logic [ErrorWidth-1:0] ERR_NONE        = 4'd0;
    localparam logic [ErrorWidth-1:0] ERR_SHORT_HDR   = 4'd1;
    localparam logic [ErrorWidth-1:0] ERR_MAGIC       = 4'd2;
    localparam logic [ErrorWidth-1:0] ERR_VERSION     = 4'd3;
    localparam logic [ErrorWidth-1:0] ERR_DTYPE       = 4'd4;
    localparam logic [ErrorWidth-1:0] ERR_TRUNC_DIMS  = 4'd5;
    localparam logic [ErrorWidth-1:0] ERR_TRUNC_SHAPE = 4'd6;
    localparam logic [ErrorWidth-1:0] ERR_TRUNC_COUNT = 4'd7;
    localparam logic [ErrorWidth-1:0] ERR_TRUNC_DATA  = 4'd8;

    // header bytes
    localparam logic [DataByteWidth-1:0] HDR_VERSION = 8'd1;
    localparam logic [DataByteWidth-1:0] HDR_DTYPE   = 8'd1;

    typedef struct packed {
        logic [KindWidth-1:0]  kind;
        logic [ValueWidth-1:0] value;
        logic [ErrorWidth-1:0] error_code;
        logic                  last;
    } result_t;

    // up to two results per byte, in order res0 then res1
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic logic [DataByteWidth-1:0] magic_byte(input logic [1:0] idx);
        logic [DataByteWidth-1:0] b;
        case (idx)
            2'd0:    b = 8'h54;  // T
            2'd1:    b = 8'h45;  // E
            2'd2:    b = 8'h4E;  // N
            default: b = 8'h53;  // S
        endcase
        return b;
    endfunction

    function automatic result_t make_result(input logic [KindWidth-1:0]  kind,
                                            input logic [ValueWidth-1:0] value,
                                            input logic [ErrorWidth-1:0] err,
                                            input logic                  last);
        result_t r;
        r.kind       = kind;
        r.value      = value;
        r.error_code = err;
        r.last       = last;
        return r;
    endfunction

endpackage

@@ sv/tfp_parse_core.sv @@
// ----------------------------------------------------------------------------
// tfp_parse_core
// Input register plus the frame state machine; turns one byte into up to two
// result records per cycle while space_ok shows room in the result queue.
// ----------------------------------------------------------------------------
module tfp_parse_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tfp_pkg::DataByteWidth-1:0]  in_byte,
    input  logic                               in_eob,
    input  logic                               space_ok,
    output tfp_pkg::push_t                     push
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_DIMS   = 3'd1,
        PH_SHAPE  = 3'd2,
        PH_COUNT  = 3'd3,
        PH_DATA   = 3'd4,
        PH_TRAIL  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        FLT_NONE    = 2'd0,
        FLT_MAGIC   = 2'd1,
        FLT_VERSION = 2'd2,
        FLT_DTYPE   = 2'd3
    } fault_t;

    logic                               valid_reg;
    logic [tfp_pkg::DataByteWidth-1:0]  byte_reg;
    logic                               eob_reg;

    phase_t                             phase_reg, phase_next;
    logic [2:0]                         pos_reg, pos_next;
    logic [tfp_pkg::ValueWidth-1:0]     acc_reg, acc_next;
    logic [tfp_pkg::ValueWidth-1:0]     shape_left_reg, shape_left_next;
    logic [tfp_pkg::ValueWidth-1:0]     elem_left_reg, elem_left_next;
    fault_t                             fault_reg, fault_next;

    logic                               step;
    logic [2:0]                         lane;
    logic [tfp_pkg::ValueWidth-1:0]     acc_ins;
    logic [tfp_pkg::ValueWidth-1:0]     shape_dec;
    logic [tfp_pkg::ValueWidth-1:0]     elem_dec;
    logic [tfp_pkg::ErrorWidth-1:0]     trunc_err;
    logic [tfp_pkg::ErrorWidth-1:0]     fault_err;
    tfp_pkg::result_t                   res0, res1;
    logic [1:0]                         res_count;

    assign step     = valid_reg && space_ok;
    assign in_ready = !valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            byte_reg <= in_byte;
            eob_reg  <= in_eob;
        end
    end

    // element words use only the low four lanes
    assign lane = (phase_reg == PH_DATA) ? {1'b0, pos_reg[1:0]} : pos_reg;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            acc_ins[8*i +: 8] = (lane == 3'(i)) ? byte_reg : acc_reg[8*i +: 8];
        end
    end

    assign shape_dec = shape_left_reg - 64'd1;
    assign elem_dec  = elem_left_reg - 64'd1;

    always_comb begin
        case (phase_reg)
            PH_DIMS:  trunc_err = tfp_pkg::ERR_TRUNC_DIMS;
            PH_SHAPE: trunc_err = tfp_pkg::ERR_TRUNC_SHAPE;
            default:  trunc_err = tfp_pkg::ERR_TRUNC_COUNT;
        endcase
    end

    always_comb begin
        unique case (fault_reg)
            FLT_MAGIC:   fault_err = tfp_pkg::ERR_MAGIC;
            FLT_VERSION: fault_err = tfp_pkg::ERR_VERSION;
            FLT_DTYPE:   fault_err = tfp_pkg::ERR_DTYPE;
            default:     fault_err = tfp_pkg::ERR_NONE;
        endcase
    end

    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        acc_next        = acc_reg;
        shape_left_next = shape_left_reg;
        elem_left_next  = elem_left_reg;
        fault_next      = fault_reg;
        res0            = '0;
        res1            = '0;
        res_count       = 2'd0;

        if (step) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    // keep the first header fault only
                    if (fault_reg == FLT_NONE) begin
                        if (!pos_reg[2] && byte_reg != tfp_pkg::magic_byte(pos_reg[1:0])) begin
                            fault_next = FLT_MAGIC;
                        end else if (pos_reg == 3'd4 && byte_reg != tfp_pkg::HDR_VERSION) begin
                            fault_next = FLT_VERSION;
                        end else if (pos_reg == 3'd5 && byte_reg != tfp_pkg::HDR_DTYPE) begin
                            fault_next = FLT_DTYPE;
                        end
                    end
                    if (pos_reg == 3'd7) begin
                        pos_next = 3'd0;
                        if (fault_reg != FLT_NONE) begin
                            res0       = tfp_pkg::make_result(tfp_pkg::KIND_ERROR, '0,
                                                              fault_err, eob_reg);
                            res_count  = 2'd1;
                            phase_next = PH_TRAIL;
                        end else begin
                            phase_next = PH_DIMS;
                            if (eob_reg) begin
                                res0      = tfp_pkg::make_result(tfp_pkg::KIND_ERROR, '0,
                                                                 tfp_pkg::ERR_TRUNC_DIMS, 1'b1);
                                res_count = 2'd1;
                            end
                        end
                    end else begin
                        pos_next = pos_reg + 3'd1;
                        if (eob_reg) begin
                            res0      = tfp_pkg::make_result(tfp_pkg::KIND_ERROR, '0,
                                                             tfp_pkg::ERR_SHORT_HDR, 1'b1);
                            res_count = 2'd1;
                        end
                    end
                end

                PH_DIMS, PH_SHAPE, PH_COUNT: begin
                    if (pos_reg != 3'd7) begin
                        acc_next = acc_ins;
                        pos_next = pos_reg + 3'd1;
                        if (eob_reg) begin
                            res0      = tfp_pkg::make_result(tfp_pkg::KIND_ERROR, '0,
                                                             trunc_err, 1'b1);
                            res_count = 2'd1;
                        end
                    end else begin
                        acc_next = '0;
                        pos_next = 3'd0;
                        if (phase_reg == PH_DIMS) begin
                            res0            = tfp_pkg::make_result(tfp_pkg::KIND_DIMS,
                                                                   acc_ins, tfp_pkg::ERR_NONE,
                                                                   1'b0);
                            shape_left_next = acc_ins;
                            phase_next      = (acc_ins != '0) ? PH_SHAPE : PH_COUNT;
                            res1            = tfp_pkg::make_result(tfp_pkg::KIND_ERROR, '0,
                                                  (acc_ins != '0) ? tfp_pkg::ERR_TRUNC_SHAPE
                                                                  : tfp_pkg::ERR_TRUNC_COUNT,
                                                  1'b1);
                            res_count       = eob_reg ? 2'd2 : 2'd1;
                        end else if (phase_reg == PH_SHAPE) begin
                            res0            = tfp_pkg::make_result(tfp_pkg::KIND_SHAPE,
                                                                   acc_ins, tfp_pkg::ERR_NONE,
                                                                   1'b0);
                            shape_left_next = shape_dec;
                            if (shape_dec == '0) begin
                                phase_next = PH_COUNT;
                            end
                            res1            = tfp_pkg::make_result(tfp_pkg::KIND_ERROR, '0,
                                                  (shape_dec != '0) ? tfp_pkg::ERR_TRUNC_SHAPE
                                                                    : tfp_pkg::ERR_TRUNC_COUNT,
                                                  1'b1);
                            res_count       = eob_reg ? 2'd2 : 2'd1;
                        end else begin
                            res0           = tfp_pkg::make_result(tfp_pkg::KIND_COUNT,
                                                                  acc_ins, tfp_pkg::ERR_NONE,
                                                                  1'b0);
                            elem_left_next = acc_ins;
                            if (acc_ins == '0) begin
                                res1       = tfp_pkg::make_result(tfp_pkg::KIND_DONE, '0,
                                                                  tfp_pkg::ERR_NONE, eob_reg);
                                res_count  = 2'd2;
                                phase_next = PH_TRAIL;
                            end else begin
                                res1       = tfp_pkg::make_result(tfp_pkg::KIND_ERROR, '0,
                                                                  tfp_pkg::ERR_TRUNC_DATA, 1'b1);
                                res_count  = eob_reg ? 2'd2 : 2'd1;
                                phase_next = PH_DATA;
                            end
                        end
                    end
                end

                PH_DATA: begin
                    if (pos_reg[1:0] != 2'd3) begin
                        acc_next = acc_ins;
                        pos_next = {1'b0, pos_reg[1:0]} + 3'd1;
                        if (eob_reg) begin
                            res0      = tfp_pkg::make_result(tfp_pkg::KIND_ERROR, '0,
                                                             tfp_pkg::ERR_TRUNC_DATA, 1'b1);
                            res_count = 2'd1;
                        end
                    end else begin
                        res0           = tfp_pkg::make_result(tfp_pkg::KIND_ELEM,
                                                              {32'd0, acc_ins[31:0]},
                                                              tfp_pkg::ERR_NONE, 1'b0);
                        acc_next       = '0;
                        pos_next       = 3'd0;
                        elem_left_next = elem_dec;
                        if (elem_dec == '0) begin
                            res1       = tfp_pkg::make_result(tfp_pkg::KIND_DONE, '0,
                                                              tfp_pkg::ERR_NONE, eob_reg);
                            res_count  = 2'd2;
                            phase_next = PH_TRAIL;
                        end else begin
                            res1      = tfp_pkg::make_result(tfp_pkg::KIND_ERROR, '0,
                                                             tfp_pkg::ERR_TRUNC_DATA, 1'b1);
                            res_count = eob_reg ? 2'd2 : 2'd1;
                        end
                    end
                end

                default: begin
                    // trailing bytes: drop until the buffer end
                end
            endcase

            // buffer end returns everything to the header phase
            if (eob_reg) begin
                phase_next      = PH_HEADER;
                pos_next        = 3'd0;
                acc_next        = '0;
                shape_left_next = '0;
                elem_left_next  = '0;
                fault_next      = FLT_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            pos_reg        <= 3'd0;
            acc_reg        <= '0;
            shape_left_reg <= '0;
            elem_left_reg  <= '0;
            fault_reg      <= FLT_NONE;
        end else begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            acc_reg        <= acc_next;
            shape_left_reg <= shape_left_next;
            elem_left_reg  <= elem_left_next;
            fault_reg      <= fault_next;
        end
    end

    assign push.count = res_count;
    assign push.res0  = res0;
    assign push.res1  = res1;

endmodule

@@ sv/tfp_result_queue.sv @@
// ----------------------------------------------------------------------------
// tfp_result_queue
// Small result queue: takes up to two records a cycle, hands one a cycle to
// the output port while out_ready is high.
// ----------------------------------------------------------------------------
module tfp_result_queue #(
    parameter int unsigned DEPTH = tfp_pkg::QueueDepth
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tfp_pkg::push_t    push,
    output logic              space_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output tfp_pkg::result_t  out_result
);

    localparam int unsigned PtrWidth = $clog2(DEPTH);
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);

    tfp_pkg::result_t       entry_reg [DEPTH];
    logic [PtrWidth-1:0]    wptr_reg, wptr_next;
    logic [PtrWidth-1:0]    rptr_reg, rptr_next;
    logic [CntWidth-1:0]    count_reg, count_next;
    logic [PtrWidth-1:0]    wptr_plus1;
    logic                   pop;

    // room for a full two-record push
    assign space_ok   = count_reg <= CntWidth'(DEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign out_result = entry_reg[rptr_reg];
    assign pop        = out_valid && out_ready;
    assign wptr_plus1 = wptr_reg + PtrWidth'(1);

    assign wptr_next  = wptr_reg + PtrWidth'(push.count);
    assign rptr_next  = pop ? rptr_reg + PtrWidth'(1) : rptr_reg;
    assign count_next = count_reg + CntWidth'(push.count) - CntWidth'(pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            entry_reg[wptr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/tensor_frame_parser.sv @@
// ----------------------------------------------------------------------------
// tensor_frame_parser
// Byte-serial parser for a binary tensor frame with a streaming interface.
// ----------------------------------------------------------------------------
// Feed the serialized buffer one byte per transaction on the s_ side, with
// s_tlast on the final byte. The parser checks the 8-byte header (magic TENS,
// version 1, dtype 1, two bytes ignored), then emits the little-endian 64-bit
// dimension count, each shape entry and the element count, followed by each
// 32-bit float element as raw bits in the low half of value, and a done
// result after the last element. A buffer that ends early yields an error
// result with last set; a bad header is reported on the eighth header byte,
// and a short header wins over a bad one. Bytes after done or an error are
// dropped silently until the buffer end, and every buffer end starts a fresh
// header. The element count is not checked against the shape. Rate: one byte
// is taken every cycle while the result queue has room; a byte passes the
// input register and then the result queue register before its first result
// appears. The output port drains one result per cycle while m_tready is high,
// so a byte that yields two results (a field closing together with done or
// with a buffer end) takes two output transfers; the input holds off only
// while the result queue (four entries by default) lacks room for two results.
// ----------------------------------------------------------------------------
module tensor_frame_parser #(
    parameter int unsigned QUEUE_DEPTH = tfp_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_buffer

    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] kind, [66:3] value, [70:67] error_code, [71] zero
    output logic [tfp_pkg::ResultDataBits-1:0] m_tdata,
    output logic        m_tlast    // last
);

    tfp_pkg::push_t   push;
    tfp_pkg::result_t head;
    logic             space_ok;

    // Register the byte, run the frame state machine, push results.
    tfp_parse_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_eob   (s_tlast),
        .space_ok (space_ok),
        .push     (push)
    );

    // Hold results until the downstream side takes them.
    tfp_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .space_ok   (space_ok),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (head)
    );

    // Pack the result: kind in the lowest bits, then value, then error_code.
    assign m_tdata = {1'b0, head.error_code, head.value, head.kind};
    assign m_tlast = head.last;

endmodule
